// ===== hdl/oracle_binary_insertion_sorter_assert.svh =====
// assertion macros for the binary insertion sorter checker
`ifndef ORACLE_BINARY_INSERTION_SORTER_ASSERT_SVH
`define ORACLE_BINARY_INSERTION_SORTER_ASSERT_SVH

// condition in the same cycle
`define OBIS_ASSERT_NOW(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("obis assertion failed");

// condition in the next cycle
`define OBIS_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("obis assertion failed");

`endif

// ===== hdl/obis_pkg.sv =====
// package with types and constants of the binary insertion sorter
`timescale 1ns / 1ps

package obis_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = 7;
    localparam int TAG_W     = 16;
    localparam int RIDX_W    = 6;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ANSWER = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_QUERY    = 2'd0,
        KIND_INSERTED = 2'd1,
        KIND_READ     = 2'd2,
        KIND_CLEARED  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BUSY      = 3'd1,
        ST_FULL      = 3'd2,
        ST_NO_SEARCH = 3'd3,
        ST_BAD_INDEX = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic [TAG_W-1:0]   new_tag;
        logic               ranks_after;
        logic [RIDX_W-1:0]  read_index;
    } t_in_word;

    typedef struct packed {
        t_kind              kind;
        logic [TAG_W-1:0]   tag;
        logic [CNT_W-1:0]   position;
        logic [CNT_W-1:0]   count;
        t_status            status;
    } t_out_word;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [TAG_W-1:0]   wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } t_ram_req;

endpackage

// ===== hdl/obis_ram.sv =====
// sorted list storage, one write and one registered read port
`timescale 1ns / 1ps

module obis_ram (
    input  logic                        i_clk,
    input  obis_pkg::t_ram_req          i_req,
    output logic [obis_pkg::TAG_W-1:0]  o_rdata
);

    logic [obis_pkg::TAG_W-1:0] r_mem [obis_pkg::MAX_ITEMS];
    logic [obis_pkg::TAG_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/oracle_binary_insertion_sorter.sv =====
// top level of the binary insertion sorter with external comparator
//
// channel   direction  handshake        word
// command   in         start / busy     i_cmd (t_in_word)
// result    out        o_valid strobe   o_result (t_out_word)
//
// rejected commands, empty-list insert and clear: result in the cycle after start
// query and read: one registered list ram read, then a registered result
// closing answer: S_SH_MOVE shifts entries up, one ram port each way, then S_SH_PLACE
// synchronous active-low reset empties the list, no clearing pass
// results are a one-cycle strobe, busy is high while the sequencer runs
`timescale 1ns / 1ps

module oracle_binary_insertion_sorter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  obis_pkg::t_in_word    i_cmd,
    output logic                  o_valid,
    output obis_pkg::t_out_word   o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RDWAIT,
        S_SH_MOVE,
        S_SH_PLACE
    } t_state;

    localparam int CW = obis_pkg::CNT_W;
    localparam int IW = obis_pkg::IDX_W;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_low, n_low;
    logic [CW-1:0]               r_high, n_high;
    logic [CW-1:0]               r_idx, n_idx;
    logic [obis_pkg::TAG_W-1:0]  r_pend, n_pend;
    logic                        r_search, n_search;
    logic                        r_valid, n_valid;
    obis_pkg::t_out_word         r_out, n_out;

    obis_pkg::t_ram_req          ram_req;
    logic [obis_pkg::TAG_W-1:0]  ram_rdata;

    logic [CW:0]                 sum_cur, sum_new;
    logic [CW-1:0]               mid_cur, mid_new, new_low, new_high, idx_m1;
    logic                        accept;

    obis_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign accept   = start && (r_state == S_IDLE);
    assign sum_cur  = {1'b0, r_low} + {1'b0, r_high};
    assign mid_cur  = sum_cur[CW:1];
    assign new_low  = i_cmd.ranks_after ? (mid_cur + CW'(1)) : r_low;
    assign new_high = i_cmd.ranks_after ? r_high : mid_cur;
    assign sum_new  = {1'b0, new_low} + {1'b0, new_high};
    assign mid_new  = sum_new[CW:1];
    assign idx_m1   = r_idx - CW'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_low    = r_low;
        n_high   = r_high;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_search = r_search;
        n_valid  = 1'b0;
        n_out    = r_out;
        ram_req  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out.tag      = '0;
                    n_out.position = '0;
                    n_out.count    = r_count;
                    n_out.status   = obis_pkg::ST_OK;
                    unique case (i_cmd.cmd)
                        obis_pkg::CMD_INSERT: begin
                            n_out.kind = obis_pkg::KIND_INSERTED;
                            n_out.tag  = i_cmd.new_tag;
                            if (r_search) begin
                                n_out.status = obis_pkg::ST_BUSY;
                                n_valid      = 1'b1;
                            end else if (r_count >= CW'(obis_pkg::MAX_ITEMS)) begin
                                n_out.status = obis_pkg::ST_FULL;
                                n_valid      = 1'b1;
                            end else if (r_count == '0) begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = '0;
                                ram_req.wdata = i_cmd.new_tag;
                                n_count       = CW'(1);
                                n_out.count   = CW'(1);
                                n_valid       = 1'b1;
                            end else begin
                                n_pend         = i_cmd.new_tag;
                                n_low          = '0;
                                n_high         = r_count;
                                n_search       = 1'b1;
                                n_out.kind     = obis_pkg::KIND_QUERY;
                                n_out.position = r_count >> 1;
                                ram_req.re     = 1'b1;
                                ram_req.raddr  = IW'(r_count >> 1);
                                n_state        = S_RDWAIT;
                            end
                        end
                        obis_pkg::CMD_ANSWER: begin
                            n_out.kind = obis_pkg::KIND_QUERY;
                            if (!r_search) begin
                                n_out.status = obis_pkg::ST_NO_SEARCH;
                                n_valid      = 1'b1;
                            end else if (new_low >= new_high) begin
                                n_low    = new_low;
                                n_high   = new_high;
                                n_search = 1'b0;
                                if (r_count > new_low) begin
                                    ram_req.re    = 1'b1;
                                    ram_req.raddr = IW'(r_count - CW'(1));
                                    n_idx         = r_count;
                                    n_state       = S_SH_MOVE;
                                end else begin
                                    n_state = S_SH_PLACE;
                                end
                            end else begin
                                n_low          = new_low;
                                n_high         = new_high;
                                n_out.position = mid_new;
                                ram_req.re     = 1'b1;
                                ram_req.raddr  = mid_new[IW-1:0];
                                n_state        = S_RDWAIT;
                            end
                        end
                        obis_pkg::CMD_READ: begin
                            n_out.kind     = obis_pkg::KIND_READ;
                            n_out.position = CW'(i_cmd.read_index);
                            if (CW'(i_cmd.read_index) < r_count) begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = IW'(i_cmd.read_index);
                                n_state       = S_RDWAIT;
                            end else begin
                                n_out.status = obis_pkg::ST_BAD_INDEX;
                                n_valid      = 1'b1;
                            end
                        end
                        obis_pkg::CMD_CLEAR: begin
                            n_count     = '0;
                            n_low       = '0;
                            n_high      = '0;
                            n_search    = 1'b0;
                            n_out.kind  = obis_pkg::KIND_CLEARED;
                            n_out.count = '0;
                            n_valid     = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                n_out.tag = ram_rdata;
                n_valid   = 1'b1;
                n_state   = S_IDLE;
            end
            S_SH_MOVE: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_idx[IW-1:0];
                ram_req.wdata = ram_rdata;
                if (idx_m1 > r_low) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = IW'(idx_m1 - CW'(1));
                    n_idx         = idx_m1;
                end else begin
                    n_state = S_SH_PLACE;
                end
            end
            S_SH_PLACE: begin
                ram_req.we     = 1'b1;
                ram_req.waddr  = r_low[IW-1:0];
                ram_req.wdata  = r_pend;
                n_count        = r_count + CW'(1);
                n_out.kind     = obis_pkg::KIND_INSERTED;
                n_out.tag      = r_pend;
                n_out.position = r_low;
                n_out.count    = r_count + CW'(1);
                n_out.status   = obis_pkg::ST_OK;
                n_valid        = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_low    <= '0;
            r_high   <= '0;
            r_idx    <= '0;
            r_pend   <= '0;
            r_search <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_low    <= n_low;
            r_high   <= n_high;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_search <= n_search;
            r_valid  <= n_valid;
            r_out    <= n_out;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

// ===== hdl/obis_checker.sv =====
// port-level checker for the binary insertion sorter and its bind
`timescale 1ns / 1ps
`include "oracle_binary_insertion_sorter_assert.svh"

module obis_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input obis_pkg::t_in_word    i_cmd,
    input logic                  o_valid,
    input obis_pkg::t_out_word   o_result
);

    // clear word answers in the next cycle with an empty list
    `OBIS_ASSERT_NEXT(a_clear_result, start && !busy && (i_cmd.cmd == obis_pkg::CMD_CLEAR), o_valid && (o_result.kind == obis_pkg::KIND_CLEARED) && (o_result.count == '0))

    // inserted position lies inside the grown list
    `OBIS_ASSERT_NOW(a_insert_pos, o_valid && (o_result.kind == obis_pkg::KIND_INSERTED) && (o_result.status == obis_pkg::ST_OK), o_result.position < o_result.count)

    // a query points at a held entry
    `OBIS_ASSERT_NOW(a_query_pos, o_valid && (o_result.kind == obis_pkg::KIND_QUERY) && (o_result.status == obis_pkg::ST_OK), o_result.position < o_result.count)

    // list never exceeds its capacity
    `OBIS_ASSERT_NOW(a_count_cap, o_valid, o_result.count <= 7'(obis_pkg::MAX_ITEMS))

endmodule

bind oracle_binary_insertion_sorter obis_checker u_obis_checker (.*);

// ===== tb/oracle_binary_insertion_sorter_test.sv =====
// self-checking testbench of the binary insertion sorter with a mirrored sorted list
`timescale 1ns / 1ps

module oracle_binary_insertion_sorter_test;
    import obis_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 80;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in_word i_cmd = '0;
    logic o_valid;
    t_out_word o_result;

    oracle_binary_insertion_sorter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // mirror of the sorted list and the search in flight
    logic [TAG_W-1:0] shadow_list [MAX_ITEMS];
    int unsigned shadow_len = 0;
    int unsigned probe_lo = 0;
    int unsigned probe_hi = 0;
    logic [TAG_W-1:0] probe_tag = '0;
    bit probe_active = 1'b0;

    t_out_word expected_results [$];

    int idle_pct = 0;
    int words_sent = 0;
    int results_seen = 0;
    int tags_placed = 0;
    int rejects_seen = 0;
    int longest_list = 0;
    int error_count = 0;
    int cycle_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_results.size());
            $display("oracle_binary_insertion_sorter_test: FAIL");
            $finish;
        end
    end

    function automatic t_out_word sorter_step(input t_in_word w);
        t_out_word r;
        int unsigned mid;
        int unsigned pos;
        r = '0;
        r.kind = KIND_QUERY;
        r.status = ST_OK;
        case (w.cmd)
            CMD_INSERT: begin
                r.kind = KIND_INSERTED;
                r.tag = w.new_tag;
                if (probe_active) begin
                    r.status = ST_BUSY;
                end else if (shadow_len >= MAX_ITEMS) begin
                    r.status = ST_FULL;
                end else if (shadow_len == 0) begin
                    shadow_list[0] = w.new_tag;
                    shadow_len = 1;
                end else begin
                    probe_tag = w.new_tag;
                    probe_lo = 0;
                    probe_hi = shadow_len;
                    probe_active = 1'b1;
                    mid = (probe_lo + probe_hi) >> 1;
                    r.kind = KIND_QUERY;
                    r.tag = shadow_list[mid];
                    r.position = CNT_W'(mid);
                end
            end
            CMD_ANSWER: begin
                if (!probe_active) begin
                    r.status = ST_NO_SEARCH;
                end else begin
                    mid = (probe_lo + probe_hi) >> 1;
                    if (w.ranks_after)
                        probe_lo = mid + 1;
                    else
                        probe_hi = mid;
                    if (probe_lo >= probe_hi) begin
                        pos = probe_lo;
                        probe_active = 1'b0;
                        for (int i = shadow_len; i > pos; i--)
                            shadow_list[i] = shadow_list[i-1];
                        shadow_list[pos] = probe_tag;
                        shadow_len++;
                        r.kind = KIND_INSERTED;
                        r.tag = probe_tag;
                        r.position = CNT_W'(pos);
                    end else begin
                        mid = (probe_lo + probe_hi) >> 1;
                        r.tag = shadow_list[mid];
                        r.position = CNT_W'(mid);
                    end
                end
            end
            CMD_READ: begin
                r.kind = KIND_READ;
                r.position = CNT_W'(w.read_index);
                if (w.read_index < shadow_len)
                    r.tag = shadow_list[w.read_index];
                else
                    r.status = ST_BAD_INDEX;
            end
            default: begin
                shadow_len = 0;
                probe_lo = 0;
                probe_hi = 0;
                probe_active = 1'b0;
                r.kind = KIND_CLEARED;
            end
        endcase
        r.count = CNT_W'(shadow_len);
        return r;
    endfunction

    // the answer an honest comparator gives; ties rank after
    function automatic bit honest_answer();
        return probe_tag >= shadow_list[(probe_lo + probe_hi) >> 1];
    endfunction

    function automatic t_in_word random_word(input t_cmd c);
        t_in_word w;
        w.cmd = c;
        w.new_tag = TAG_W'($urandom);
        w.ranks_after = 1'($urandom);
        w.read_index = RIDX_W'($urandom);
        return w;
    endfunction

    task automatic note_failure(input string msg);
        if (error_count < 10)
            $display("[%0t] %s", $realtime, msg);
        error_count++;
    endtask

    task automatic issue_command(input t_in_word w);
        t_out_word want;
        @(negedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        start = 1'b1;
        i_cmd = w;
        forever begin
            @(posedge i_clk);
            if (busy === 1'b0)
                break;
        end
        want = sorter_step(w);
        expected_results.push_back(want);
        words_sent++;
        if (want.kind == KIND_INSERTED && want.status == ST_OK)
            tags_placed++;
        if (want.status != ST_OK)
            rejects_seen++;
        if (shadow_len > longest_list)
            longest_list = shadow_len;
    endtask

    task automatic do_insert(input logic [TAG_W-1:0] t);
        t_in_word w;
        w = random_word(CMD_INSERT);
        w.new_tag = t;
        issue_command(w);
    endtask

    task automatic do_answer(input bit after);
        t_in_word w;
        w = random_word(CMD_ANSWER);
        w.ranks_after = after;
        issue_command(w);
    endtask

    task automatic do_read(input int idx);
        t_in_word w;
        w = random_word(CMD_READ);
        w.read_index = RIDX_W'(idx);
        issue_command(w);
    endtask

    task automatic do_clear();
        issue_command(random_word(CMD_CLEAR));
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                note_failure($sformatf("unexpected result kind %0d tag %h pos %0d count %0d st %0d",
                                       o_result.kind, o_result.tag, o_result.position,
                                       o_result.count, o_result.status));
            end else begin
                want = expected_results.pop_front();
                if (o_result.kind !== want.kind || o_result.tag !== want.tag ||
                    o_result.position !== want.position || o_result.count !== want.count ||
                    o_result.status !== want.status)
                    note_failure($sformatf({"mismatch: expected kind %0d tag %h pos %0d ",
                                            "count %0d st %0d, got kind %0d tag %h pos %0d ",
                                            "count %0d st %0d"},
                                           want.kind, want.tag, want.position, want.count,
                                           want.status, o_result.kind, o_result.tag,
                                           o_result.position, o_result.count,
                                           o_result.status));
            end
        end
    end

    task automatic test_empty_list_misuse();
        do_clear();
        do_answer(1'b1);
        do_read(0);
        do_read(63);
        do_insert(16'hFFFF);
        do_read(0);
        do_read(1);
        hold_until_drained();
    endtask

    task automatic test_search_paths();
        do_insert(16'h0000);
        do_answer(1'b0);
        do_insert(16'h8000);
        do_answer(honest_answer());
        do_answer(honest_answer());
        do_read(1);
        do_insert(16'h1234);
        do_insert(16'hABCD);
        do_read(2);
        do_read(5);
        do_clear();
        do_answer(1'b0);
        do_insert(16'h7777);
        hold_until_drained();
    endtask

    task automatic test_full_list();
        do_clear();
        while (shadow_len < MAX_ITEMS) begin
            do_insert(TAG_W'($urandom));
            while (probe_active) begin
                if ($urandom_range(9) == 0)
                    do_answer(1'($urandom));
                else
                    do_answer(honest_answer());
            end
        end
        do_insert(16'hFFFF);
        do_insert(TAG_W'($urandom));
        do_read(63);
        do_read(0);
        repeat (4) do_read($urandom_range(63));
        do_answer(1'b1);
        do_clear();
        hold_until_drained();
    endtask

    task automatic test_random_traffic(input int pct, input int n_words);
        int stop_at;
        int pick;
        idle_pct = pct;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (probe_active) begin
                if (pick < 80)
                    do_answer(honest_answer());
                else if (pick < 85)
                    do_answer(1'($urandom));
                else if (pick < 90)
                    do_insert(TAG_W'($urandom));
                else if (pick < 96)
                    do_read($urandom_range(63));
                else
                    do_clear();
            end else begin
                if (pick < 60)
                    do_insert(TAG_W'($urandom));
                else if (pick < 75 && shadow_len > 0)
                    do_read($urandom_range(shadow_len - 1));
                else if (pick < 80)
                    do_read($urandom_range(63));
                else if (pick < 86)
                    do_answer(1'($urandom));
                else if (pick < 90)
                    do_clear();
                else if (pick < 97)
                    do_insert(TAG_W'($urandom));
                else
                    hold_until_drained();
            end
        end
        hold_until_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list_misuse();
        test_search_paths();
        test_full_list();
        test_random_traffic(45, 110);
        test_random_traffic(0, 80);
        test_random_traffic(38, 100);

        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words sent, %0d results checked, %0d tags placed, %0d rejected",
                 words_sent, results_seen, tags_placed, rejects_seen);
        $display("list grew to %0d entries; misuse, mid-search clears and gaps exercised",
                 longest_list);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("oracle_binary_insertion_sorter_test: PASS");
        end else begin
            $display("%0d failures, %0d results never arrived",
                     error_count, expected_results.size());
            $display("oracle_binary_insertion_sorter_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/obis_pkg.sv
hdl/obis_ram.sv
hdl/oracle_binary_insertion_sorter.sv
hdl/obis_checker.sv
tb/oracle_binary_insertion_sorter_test.sv
